[sv/tdtc_pkg.sv]
`timescale 1ns / 1ps
package tdtc_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 33;
    localparam int Q_W      = 42;
    localparam int MD_STEPS = 40;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_TO_TIME  = 2'd1;
    localparam logic [1:0] CMD_TO_DEPTH = 2'd2;
    localparam logic [1:0] CMD_VEL      = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] time_val;
        logic signed [DATA_W-1:0] depth_val;
    } t_entry;

    typedef struct packed {
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
        logic signed [OP_W-1:0] c;
    } t_md_req;

endpackage

[sv/time_depth_table_convert_core.sv]
`timescale 1ns / 1ps
// Write beat: the slot is loaded on the accept edge.
// Query beat: s binary search steps (at most ceil(log2(entry count - 1))), then a multiply and,
//   unless the quotient saturates, a 40-step divide. Exact hits skip the multiply and divide,
//   and so do undefined results.
// One item at a time; ready returns on the edge that loads the result, which may then wait.
// Synchronous active-low reset clears control and entry_count; table contents stay unknown.
module time_depth_table_convert_core import tdtc_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, entry_depth, entry_time, query_value, zero pad
    input  logic [111:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value
    output logic [31:0]  m_axis_tdata,
    // result_valid, exact_hit
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [10:0]  i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK0 = 4'd1;
    localparam logic [3:0] S_CHKL = 4'd2;
    localparam logic [3:0] S_BS   = 4'd3;
    localparam logic [3:0] S_SEG  = 4'd4;
    localparam logic [3:0] S_HIT  = 4'd5;
    localparam logic [3:0] S_SEGA = 4'd6;
    localparam logic [3:0] S_SEGB = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
    localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;

    logic [3:0]               r_state, n_state;
    logic [10:0]              r_count;
    logic [1:0]               r_cmd, n_cmd;
    logic signed [31:0]       r_z, n_z;
    logic [CW-1:0]            r_lo, n_lo, r_hi, n_hi, r_pos, n_pos;
    logic                     r_below, n_below;
    t_entry                   r_ea, n_ea;
    logic signed [31:0]       r_base, n_base;
    logic signed [31:0]       r_res, n_res;
    logic                     r_res_ok, n_res_ok, r_res_hit, n_res_hit;
    logic                     r_ovalid;
    logic [31:0]              r_odata;
    logic [1:0]               r_ouser;

    logic [CW-1:0]            w_n, w_nm1, w_nm2, w_addr, w_mid, w_idx;
    logic                     w_we, w_idx_ok, w_start, w_done, w_use_depth, w_last;
    logic                     w_seg_ok, w_out_free;
    t_entry                   w_rd, w_wentry;
    logic signed [31:0]       w_din, w_dout, w_ea_din, w_ea_dout;
    logic signed [32:0]       w_ddin, w_ddout, w_zs;
    t_md_req                  w_req;
    logic signed [Q_W-1:0]    w_q;
    logic signed [42:0]       w_sum;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);

    assign w_n   = (CW'(r_count) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_count);
    assign w_nm1 = w_n - CW'(1);
    assign w_nm2 = w_n - CW'(2);
    assign w_idx    = CW'(s_axis_tdata[9:0]);
    assign w_idx_ok = (w_idx < CW'(TABLE_DEPTH));
    assign w_wentry.depth_val = s_axis_tdata[41:10];
    assign w_wentry.time_val  = s_axis_tdata[73:42];

    tdtc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx[AW-1:0]),
        .i_wdata (w_wentry),
        .i_raddr (w_addr[AW-1:0]),
        .o_rdata (w_rd)
    );

    assign w_use_depth = (r_cmd != CMD_TO_DEPTH);
    assign w_din     = w_use_depth ? w_rd.depth_val : w_rd.time_val;
    assign w_dout    = w_use_depth ? w_rd.time_val : w_rd.depth_val;
    assign w_ea_din  = w_use_depth ? r_ea.depth_val : r_ea.time_val;
    assign w_ea_dout = w_use_depth ? r_ea.time_val : r_ea.depth_val;
    assign w_ddin    = {w_din[31], w_din} - {w_ea_din[31], w_ea_din};
    assign w_ddout   = {w_dout[31], w_dout} - {w_ea_dout[31], w_ea_dout};
    assign w_last    = !r_below && (r_pos == w_nm1);
    assign w_zs      = w_last ? ({r_z[31], r_z} - {w_din[31], w_din})
                              : ({r_z[31], r_z} - {w_ea_din[31], w_ea_din});
    assign w_mid     = (r_lo + r_hi) >> 1;

    always_comb begin
        if (r_cmd == CMD_VEL) begin
            w_req.a  = w_ddin;
            w_req.b  = 33'sd65536;
            w_req.c  = w_ddout;
            w_seg_ok = (w_ddout != '0);
        end else begin
            w_req.a  = w_zs;
            w_req.b  = w_ddout;
            w_req.c  = w_ddin;
            w_seg_ok = (w_ddin != '0) &&
                       (!((r_below || w_last) && r_cmd == CMD_TO_TIME) || w_ddout != '0);
        end
    end

    tdtc_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_q     (w_q)
    );

    assign w_sum      = {{11{r_base[31]}}, r_base} + {w_q[Q_W-1], w_q};
    assign w_out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_z       = r_z;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_below   = r_below;
        n_ea      = r_ea;
        n_base    = r_base;
        n_res     = r_res;
        n_res_ok  = r_res_ok;
        n_res_hit = r_res_hit;
        w_addr    = '0;
        w_we      = 1'b0;
        w_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == CMD_WRITE) begin
                        w_we = w_idx_ok;
                    end else begin
                        n_cmd     = s_axis_tuser;
                        n_z       = s_axis_tdata[105:74];
                        n_res     = '0;
                        n_res_ok  = 1'b0;
                        n_res_hit = 1'b0;
                        n_state   = (w_n == '0) ? S_FIN : S_CHK0;
                    end
                end
            end
            S_CHK0: begin
                if (r_z < w_din) begin
                    n_below = 1'b1;
                    n_state = S_SEG;
                end else begin
                    n_below = 1'b0;
                    w_addr  = w_nm1;
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                if (r_z >= w_din) begin
                    n_pos   = w_nm1;
                    n_state = S_SEG;
                end else begin
                    n_lo = '0;
                    n_hi = w_nm1;
                    if (w_nm1 > CW'(1)) begin
                        w_addr  = w_nm1 >> 1;
                        n_state = S_BS;
                    end else begin
                        n_pos   = '0;
                        n_state = S_SEG;
                    end
                end
            end
            S_BS: begin
                if (w_din <= r_z) begin
                    n_lo = w_mid;
                end else begin
                    n_hi = w_mid;
                end
                if (n_hi - n_lo > CW'(1)) begin
                    w_addr = (n_lo + n_hi) >> 1;
                end else begin
                    n_pos   = n_lo;
                    n_state = S_SEG;
                end
            end
            S_SEG: begin
                w_addr  = r_pos;
                n_state = S_HIT;
            end
            S_HIT: begin
                if (!r_below && r_cmd != CMD_VEL && w_din == r_z) begin
                    n_res     = w_dout;
                    n_res_ok  = 1'b1;
                    n_res_hit = 1'b1;
                    n_state   = S_FIN;
                end else if (w_n < CW'(2)) begin
                    n_state = S_FIN;
                end else begin
                    if (r_below) begin
                        n_lo = '0;
                    end else if (r_pos == w_nm1) begin
                        n_lo = w_nm2;
                    end else if (r_cmd == CMD_VEL) begin
                        n_lo = (r_pos == '0) ? '0 : r_pos - CW'(1);
                    end else begin
                        n_lo = r_pos;
                    end
                    w_addr  = n_lo;
                    n_state = S_SEGA;
                end
            end
            S_SEGA: begin
                n_ea    = w_rd;
                w_addr  = r_lo + CW'(1);
                n_state = S_SEGB;
            end
            S_SEGB: begin
                if (r_cmd == CMD_VEL) begin
                    n_base = '0;
                end else begin
                    n_base = w_last ? w_dout : w_ea_dout;
                end
                if (w_seg_ok) begin
                    w_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_done) begin
                    if (w_sum > SAT_MAX) begin
                        n_res = 32'h7FFF_FFFF;
                    end else if (w_sum < SAT_MIN) begin
                        n_res = 32'h8000_0000;
                    end else begin
                        n_res = w_sum[31:0];
                    end
                    n_res_ok = 1'b1;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_z       <= n_z;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_pos     <= n_pos;
        r_below   <= n_below;
        r_ea      <= n_ea;
        r_base    <= n_base;
        r_res     <= n_res;
        r_res_ok  <= n_res_ok;
        r_res_hit <= n_res_hit;
        if (r_state == S_FIN && w_out_free) begin
            r_odata <= r_res;
            r_ouser <= {r_res_hit, r_res_ok};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

[sv/tdtc_ram.sv]
`timescale 1ns / 1ps
module tdtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tdtc_mdu.sv]
`timescale 1ns / 1ps
module tdtc_mdu import tdtc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_md_req               i_req,
    output logic                  o_done,
    output logic signed [Q_W-1:0] o_q
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_CHK  = 2'd2;
    localparam logic [1:0] P_DIV  = 2'd3;
    localparam int CNT_W = $clog2(MD_STEPS + 1);

    function automatic logic [DATA_W-1:0] f_mag(input logic signed [OP_W-1:0] v);
        logic [OP_W-1:0] t;
        t = v[OP_W-1] ? -v : v;
        return t[DATA_W-1:0];
    endfunction

    logic [1:0]            r_phase, n_phase;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic                  r_sat, n_sat;
    logic [DATA_W-1:0]     r_ua, n_ua, r_ub, n_ub, r_uc, n_uc;
    logic [63:0]           r_prod, n_prod;
    logic [DATA_W-1:0]     r_rem, n_rem;
    logic [MD_STEPS-1:0]   r_quo, n_quo;
    logic [DATA_W:0]       w_trial;
    logic [MD_STEPS:0]     w_mag;

    assign w_trial = {r_rem, r_quo[MD_STEPS-1]};

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_sat   = r_sat;
        n_ua    = r_ua;
        n_ub    = r_ub;
        n_uc    = r_uc;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_quo   = r_quo;
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_ua    = f_mag(i_req.a);
                    n_ub    = f_mag(i_req.b);
                    n_uc    = f_mag(i_req.c);
                    n_neg   = i_req.a[OP_W-1] ^ i_req.b[OP_W-1] ^ i_req.c[OP_W-1];
                    n_phase = P_MUL;
                end
            end
            P_MUL: begin
                n_prod  = 64'(r_ua) * 64'(r_ub);
                n_phase = P_CHK;
            end
            P_CHK: begin
                if ({8'd0, r_prod[63:MD_STEPS]} >= r_uc) begin
                    n_sat   = 1'b1;
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else begin
                    n_sat   = 1'b0;
                    n_rem   = {8'd0, r_prod[63:MD_STEPS]};
                    n_quo   = r_prod[MD_STEPS-1:0];
                    n_cnt   = CNT_W'(MD_STEPS);
                    n_phase = P_DIV;
                end
            end
            P_DIV: begin
                if (w_trial >= {1'b0, r_uc}) begin
                    n_rem = DATA_W'(w_trial - {1'b0, r_uc});
                    n_quo = {r_quo[MD_STEPS-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[DATA_W-1:0];
                    n_quo = {r_quo[MD_STEPS-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end
            end
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_sat  <= n_sat;
        r_ua   <= n_ua;
        r_ub   <= n_ub;
        r_uc   <= n_uc;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    assign w_mag  = r_sat ? {1'b1, {MD_STEPS{1'b0}}} : {1'b0, r_quo};
    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

endmodule
